// ----- sv/hptp_pkg.sv -----
// ----------------------------------------------------------------------------
// hptp_pkg
// Shared widths, character codes and the character class bundle of the
// hex pair timestamp parser.
// ----------------------------------------------------------------------------
package hptp_pkg;

    localparam int MAX_DIGITS_DEF = 8;   // digits per field before overflow
    localparam int VAL_W          = 32;  // width of each accumulated field
    localparam int CHAR_W         = 8;
    localparam int HEX_W          = 4;

    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_F    = 8'h66;
    localparam logic [HEX_W-1:0]  HEX_TEN      = 4'hA;

    // item kinds carried in tuser
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // classification of one character
    typedef struct packed {
        logic             is_hex;
        logic [HEX_W-1:0] hex_val;
        logic             is_space;
        logic             is_slash;
    } char_class_t;

endpackage

// ----- sv/hptp_decode.sv -----
// ----------------------------------------------------------------------------
// hptp_decode
// Character classifier: hex digit value, whitespace and slash detection.
// ----------------------------------------------------------------------------
module hptp_decode
    import hptp_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    output char_class_t       cls
);

    logic is_dec;
    logic is_up;
    logic is_lo;

    assign is_dec = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_up  = (character >= CHAR_UP_A) && (character <= CHAR_UP_F);
    assign is_lo  = (character >= CHAR_LO_A) && (character <= CHAR_LO_F);

    always_comb
    begin
        cls.is_hex   = is_dec || is_up || is_lo;
        cls.is_slash = (character == CHAR_SLASH);
        cls.is_space = (character == CHAR_SPACE) ||
                       ((character >= CHAR_TAB) && (character <= CHAR_CR));
        if (is_dec)
        begin
            cls.hex_val = HEX_W'(character - CHAR_ZERO);
        end
        else if (is_up)
        begin
            cls.hex_val = HEX_W'(character - CHAR_UP_A) + HEX_TEN;
        end
        else if (is_lo)
        begin
            cls.hex_val = HEX_W'(character - CHAR_LO_A) + HEX_TEN;
        end
        else
        begin
            cls.hex_val = '0;
        end
    end

endmodule

// ----- sv/hptp_core.sv -----
// ----------------------------------------------------------------------------
// hptp_core
// Parse state, per-item step logic and the result register.
// ----------------------------------------------------------------------------
module hptp_core
    import hptp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              skip_ws,
    input  logic              step_valid,
    input  logic              step_kind,
    input  char_class_t       cls,
    output logic              advance,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [2*VAL_W-1:0] m_axis_tdata,   // [31:0] upper_value, [63:32] lower_value
    output logic [1:0]        m_axis_tuser     // [0] valid_res, [1] terminator_returned
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    typedef enum logic [1:0] {PH_START, PH_UPPER, PH_LOWER} phase_t;

    phase_t             phase_reg, phase_next, ph_eff;
    logic [VAL_W-1:0]   upper_reg, upper_next;
    logic [VAL_W-1:0]   lower_reg, lower_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_upper_reg, out_upper_next;
    logic [VAL_W-1:0]   out_lower_reg, out_lower_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_term_reg, out_term_next;

    logic hit;
    logic in_start;
    logic has_res;
    logic ret;
    logic ok;

    assign advance = !out_valid_reg || m_axis_tready;
    assign hit     = step_valid && advance;

    // unused phase code behaves like the start phase
    assign in_start = (phase_reg != PH_UPPER) && (phase_reg != PH_LOWER);
    assign ok       = (phase_reg == PH_LOWER) && (cnt_reg != '0) && !ovf_reg;

    always_comb
    begin
        case (phase_reg)
            PH_UPPER: ph_eff = PH_UPPER;
            PH_LOWER: ph_eff = PH_LOWER;
            default:  ph_eff = PH_UPPER;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_upper_next = out_upper_reg;
        out_lower_next = out_lower_reg;
        out_ok_next    = out_ok_reg;
        out_term_next  = out_term_reg;
        has_res        = 1'b0;
        ret            = 1'b0;

        if (hit)
        begin
            if (step_kind == KIND_EOS)
            begin
                has_res = 1'b1;
            end
            else if (in_start && skip_ws && cls.is_space)
            begin
                phase_next = phase_reg;
            end
            else if (cls.is_hex)
            begin
                phase_next = ph_eff;
                if (ph_eff == PH_UPPER)
                begin
                    upper_next = {upper_reg[VAL_W-HEX_W-1:0], cls.hex_val};
                end
                else
                begin
                    lower_next = {lower_reg[VAL_W-HEX_W-1:0], cls.hex_val};
                end
                if (cnt_reg <= CNT_MAX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                ovf_next = (cnt_next > CNT_MAX);
            end
            else if (!ovf_reg && (ph_eff == PH_UPPER) && cls.is_slash && (cnt_reg != '0))
            begin
                phase_next = PH_LOWER;
                cnt_next   = '0;
            end
            else
            begin
                has_res = 1'b1;
                ret     = 1'b1;
            end

            if (has_res)
            begin
                phase_next = PH_START;
                upper_next = '0;
                lower_next = '0;
                cnt_next   = '0;
                ovf_next   = 1'b0;
            end
        end

        if (advance)
        begin
            out_valid_next = hit && has_res;
            if (hit && has_res)
            begin
                out_ok_next    = ok;
                out_term_next  = ret;
                out_upper_next = ok ? upper_reg : '0;
                out_lower_next = ok ? lower_reg : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            upper_reg     <= '0;
            lower_reg     <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_upper_reg <= '0;
            out_lower_reg <= '0;
            out_ok_reg    <= 1'b0;
            out_term_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            out_upper_reg <= out_upper_next;
            out_lower_reg <= out_lower_next;
            out_ok_reg    <= out_ok_next;
            out_term_reg  <= out_term_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_lower_reg, out_upper_reg};
    assign m_axis_tuser  = {out_term_reg, out_ok_reg};

    // a finished parse always leaves the parser in the start phase
    a_finish_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && has_res) |=> (phase_reg == PH_START))
        else $error("parser not back in start phase after a result");

    // digit count saturates one above the field limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS + 1))
        else $error("digit count beyond saturation");

    // overflow is only flagged with a saturated count
    a_ovf_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_reg == CNT_W'(MAX_DIGITS + 1)))
        else $error("overflow flag without saturated count");

    // end of stream yields a result with no returned terminator
    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && (step_kind == KIND_EOS)) |=> (out_valid_reg && !out_term_reg))
        else $error("end of stream did not give a plain result");

endmodule

// ----- sv/hex_pair_timestamp_parser_unit.sv -----
// ----------------------------------------------------------------------------
// hex_pair_timestamp_parser_unit
// Streaming parser for "upper/lower" hex timestamps, one character a transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one character (tdata) or an end-of-stream mark
// (tuser = 1). The block takes one transfer per clock as long as results are
// taken. A result held on the output stalls the step stage, and the input
// stops once its one-entry register is full as well. A character is held in
// an input register, then classified and folded into the parse state by the
// step logic (digit decode and a 4-bit shift-in); that state feedback loop
// is what sets the rate of one item per cycle while results are taken.
// A result is offered from the output register once the transfer that ends
// the parse has passed the input register and the step: an end of stream,
// or a character that is not consumed (terminator_returned = 1).
// valid_res is set only when the lower field holds 1..MAX_DIGITS digits and
// no field overflowed; otherwise both values read as zero. After every
// result the parser is back at its start phase. skip_whitespace (reset 1)
// lets leading whitespace be dropped; write it only while the block is idle.
// ----------------------------------------------------------------------------
module hex_pair_timestamp_parser_unit
    import hptp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration: skip_whitespace
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] character
    input  logic               s_axis_tuser,   // [0] kind

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [2*VAL_W-1:0] m_axis_tdata,   // [31:0] upper_value, [63:32] lower_value
    output logic [1:0]         m_axis_tuser    // [0] valid_res, [1] terminator_returned
);

    logic              skip_ws_reg;
    logic              in_valid_reg, in_valid_next;
    logic              in_kind_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              advance;
    logic              s_take;
    char_class_t       cls;

    assign cfg_ready     = 1'b1;
    // the input stage frees whenever the step stage moves
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_ws_reg  <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                skip_ws_reg <= cfg_data;
            end
        end
    end

    // payload of the input stage
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_kind_reg <= s_axis_tuser;
            in_char_reg <= s_axis_tdata;
        end
    end

    hptp_decode u_decode (
        .character (in_char_reg),
        .cls       (cls)
    );

    hptp_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .skip_ws       (skip_ws_reg),
        .step_valid    (in_valid_reg),
        .step_kind     (in_kind_reg),
        .cls           (cls),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
